// ===== rtl/kmwc_pkg.sv =====
// Shared types, codes and constants for the maze wall carver.
package kmwc_pkg;

  // Default grid capacity
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Field widths
  localparam int CFG_W   = 7;
  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int SIDE_W  = 2;
  localparam int WALL_W  = 4;

  // Coordinate and dimension width (covers dimensions up to 511)
  localparam int DIM_W  = 9;
  localparam int PROD_W = 2 * DIM_W;

  // Configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FORCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // Side codes
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd3;

  localparam logic [WALL_W-1:0] WALLS_ALL = 4'hF;

  // Sequencer to union-find unit
  typedef struct packed {
    logic start;
    logic clear_wr;
  } uf_ctl_t;

  // Union-find unit back to sequencer
  typedef struct packed {
    logic done;
    logic merged;
  } uf_sts_t;

  // Wall bit of one side
  function automatic logic [WALL_W-1:0] side_mask(input logic [SIDE_W-1:0] s);
    side_mask = WALL_W'(1) << s;
  endfunction

endpackage

// ===== rtl/kruskal_maze_wall_carver_core.sv =====
// Maze wall carver top level: sequencer, wall memory, union-find unit and output register.
// From acceptance to result: a cell outside the grid goes from branch to done; a query or
//   a neighbor outside the grid only reads the cell; force open writes the cell and neighbor.
//   Offer waits for the root finds, with a rank bump on a tie; if merged it writes the cell
//   and the neighbor. One transaction at a time; a result held in the output register keeps
//   the sequencer in its done state, which also stalls the next input.
// Clear and reset sweep every cell, one a cycle.
module kruskal_maze_wall_carver_core import kmwc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [COORD_W-1:0] cell_x,
  input  logic [COORD_W-1:0] cell_y,
  input  logic [SIDE_W-1:0]  side,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               removed,
  output logic [WALL_W-1:0]  wall_bits,
  output logic               side_wall,
  output logic               status
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int IW    = $clog2(CELLS);
  localparam logic [DIM_W-1:0] MAXW_D = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH_D = DIM_W'(MAX_HEIGHT);
  localparam logic [IW-1:0]    LAST_IDX = IW'(CELLS - 1);

  typedef enum logic [7:0] {
    T_SWEEP  = 8'b00000001,
    T_IDLE   = 8'b00000010,
    T_BRANCH = 8'b00000100,
    T_UNION  = 8'b00001000,
    T_WRD    = 8'b00010000,
    T_WCELL  = 8'b00100000,
    T_WNB    = 8'b01000000,
    T_DONE   = 8'b10000000
  } state_t;

  state_t state, state_next;

  // Clamp a dimension register to 1..max
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r,
                                               input logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] rr;
    rr = DIM_W'(r);
    if (r == '0) eff_dim = DIM_W'(1);
    else if (rr > mx) eff_dim = mx;
    else eff_dim = rr;
  endfunction

  // Configuration
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  // Decode of the incoming transaction
  logic [DIM_W-1:0] w_eff, h_eff, x_d, y_d, nx_d, ny_d;
  logic             in_grid_d, nb_ok_d;
  logic [IW-1:0]    cell_d, nb_d, a_d, b_d;

  // Captured transaction
  logic [CMD_W-1:0]  cmd_q;
  logic [SIDE_W-1:0] side_q;
  logic [SIDE_W-1:0] opp_q;
  logic [IW-1:0]     cell_idx, nb_idx, a_idx, b_idx;
  logic              in_grid_q, nb_ok_q, open_q;

  // Pending result
  logic              res_removed;
  logic [WALL_W-1:0] res_walls;
  logic              res_status;

  // Sweep
  logic [IW-1:0] clr_addr;
  logic          clr_result;

  // Wall memory
  logic [WALL_W-1:0] wall_mem [CELLS];
  logic [WALL_W-1:0] wall_rd;
  logic              wall_we;
  logic [IW-1:0]     wall_waddr;
  logic [WALL_W-1:0] wall_wdata;
  logic [IW-1:0]     wall_raddr;

  uf_ctl_t uf_ctl;
  uf_sts_t uf_sts;

  logic accept;
  logic slot_free;
  logic sweep_last;

  assign in_stall   = (state != T_IDLE);
  assign accept     = in_valid && (state == T_IDLE);
  assign slot_free  = !out_valid || !out_stall;
  assign sweep_last = (clr_addr == LAST_IDX);
  assign opp_q      = side_q + SIDE_W'(2);

  // Locate the cell and its neighbor
  always_comb begin
    w_eff     = eff_dim(grid_width, MAXW_D);
    h_eff     = eff_dim(grid_height, MAXH_D);
    x_d       = DIM_W'(cell_x);
    y_d       = DIM_W'(cell_y);
    in_grid_d = (x_d < w_eff) && (y_d < h_eff);
    nx_d      = x_d;
    ny_d      = y_d;
    nb_ok_d   = 1'b1;
    unique case (side)
      SIDE_TOP: begin
        nb_ok_d = (y_d != '0);
        ny_d    = y_d - DIM_W'(1);
      end
      SIDE_RIGHT: begin
        nx_d    = x_d + DIM_W'(1);
        nb_ok_d = (nx_d < w_eff);
      end
      SIDE_BOTTOM: begin
        ny_d    = y_d + DIM_W'(1);
        nb_ok_d = (ny_d < h_eff);
      end
      SIDE_LEFT: begin
        nb_ok_d = (x_d != '0);
        nx_d    = x_d - DIM_W'(1);
      end
    endcase
    cell_d = IW'(PROD_W'(y_d) * PROD_W'(MAX_WIDTH) + PROD_W'(x_d));
    nb_d   = IW'(PROD_W'(ny_d) * PROD_W'(MAX_WIDTH) + PROD_W'(nx_d));
    // a is the top or left cell of the pair
    a_d = (side == SIDE_TOP || side == SIDE_LEFT) ? nb_d : cell_d;
    b_d = (side == SIDE_TOP || side == SIDE_LEFT) ? cell_d : nb_d;
  end

  // Sequencer and memory control
  always_comb begin
    state_next = state;
    wall_we    = 1'b0;
    wall_waddr = cell_idx;
    wall_wdata = wall_rd & ~side_mask(side_q);
    wall_raddr = cell_idx;
    uf_ctl     = '0;
    unique case (state)
      T_SWEEP: begin
        wall_we         = 1'b1;
        wall_waddr      = clr_addr;
        wall_wdata      = WALLS_ALL;
        uf_ctl.clear_wr = 1'b1;
        if (sweep_last) state_next = clr_result ? T_DONE : T_IDLE;
      end
      T_IDLE: begin
        if (in_valid) state_next = T_BRANCH;
      end
      T_BRANCH: begin
        if (cmd_q == CMD_CLEAR) begin
          state_next = T_SWEEP;
        end else if (!in_grid_q) begin
          state_next = T_DONE;
        end else if (cmd_q == CMD_OFFER && nb_ok_q) begin
          uf_ctl.start = 1'b1;
          state_next   = T_UNION;
        end else begin
          state_next = T_WCELL;
        end
      end
      T_UNION: begin
        if (uf_sts.done) state_next = T_WRD;
      end
      T_WRD: begin
        state_next = T_WCELL;
      end
      T_WCELL: begin
        if (open_q) begin
          wall_we    = 1'b1;
          wall_raddr = nb_idx;
          state_next = T_WNB;
        end else begin
          state_next = T_DONE;
        end
      end
      T_WNB: begin
        wall_we    = 1'b1;
        wall_waddr = nb_idx;
        wall_wdata = wall_rd & ~side_mask(opp_q);
        state_next = T_DONE;
      end
      T_DONE: begin
        if (slot_free) state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_SWEEP;
      clr_addr    <= '0;
      clr_result  <= 1'b0;
      out_valid   <= 1'b0;
      grid_width  <= CFG_DIM_RESET;
      grid_height <= CFG_DIM_RESET;
    end else begin
      state <= state_next;
      if (state == T_SWEEP) begin
        clr_addr <= sweep_last ? '0 : clr_addr + IW'(1);
        if (sweep_last) clr_result <= 1'b0;
      end
      if (state == T_BRANCH && cmd_q == CMD_CLEAR) clr_result <= 1'b1;
      if (state == T_DONE && slot_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
        endcase
      end
    end
  end

  // Capture the transaction and build the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= command;
      side_q    <= side;
      cell_idx  <= cell_d;
      nb_idx    <= nb_d;
      a_idx     <= a_d;
      b_idx     <= b_d;
      in_grid_q <= in_grid_d;
      nb_ok_q   <= nb_ok_d;
    end
    case (state)
      T_BRANCH: begin
        res_removed <= 1'b0;
        res_walls   <= WALLS_ALL;
        res_status  <= (cmd_q != CMD_CLEAR) &&
                       (!in_grid_q || (!nb_ok_q && (cmd_q != CMD_QUERY)));
        if (cmd_q != CMD_CLEAR && in_grid_q) begin
          open_q <= (cmd_q == CMD_FORCE) && nb_ok_q;
        end
      end
      T_UNION: begin
        if (uf_sts.done) open_q <= uf_sts.merged;
      end
      T_WCELL: begin
        if (open_q) begin
          res_walls   <= wall_wdata;
          res_removed <= (cmd_q == CMD_FORCE) ? wall_rd[side_q] : 1'b1;
        end else begin
          res_walls   <= wall_rd;
          res_removed <= 1'b0;
        end
      end
      default: ;
    endcase
    if (state == T_DONE && slot_free) begin
      removed   <= res_removed;
      wall_bits <= res_walls;
      side_wall <= res_walls[side_q];
      status    <= res_status;
    end
  end

  // Wall memory
  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
    wall_rd <= wall_mem[wall_raddr];
  end

  kmwc_union #(
    .CELLS(CELLS)
  ) u_union (
    .clk     (clk),
    .rst     (rst),
    .ctl     (uf_ctl),
    .a_idx   (a_idx),
    .b_idx   (b_idx),
    .clr_idx (clr_addr),
    .sts     (uf_sts)
  );

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    uf_sts.done |-> (state == T_UNION))
    else $error("union finished outside its wait state");

  a_removed_open: assert property (@(posedge clk) disable iff (rst)
    (out_valid && removed) |-> !side_wall)
    else $error("opened wall reported present");

  a_status_no_remove: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> !removed)
    else $error("wall opened on an out-of-grid transaction");

  a_pair_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == T_WNB) |-> (cell_idx != nb_idx))
    else $error("neighbor write hits the named cell");
`endif

endmodule

// ===== rtl/kmwc_union.sv =====
// Union-find unit: root finds and union by rank over a parent/rank memory.
module kmwc_union import kmwc_pkg::*; #(
  parameter int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  localparam int IW = $clog2(CELLS)
) (
  input  logic          clk,
  input  logic          rst,
  input  uf_ctl_t       ctl,
  input  logic [IW-1:0] a_idx,
  input  logic [IW-1:0] b_idx,
  input  logic [IW-1:0] clr_idx,
  output uf_sts_t       sts
);

  localparam int RW = $clog2($clog2(CELLS) + 1);
  localparam int EW = RW + IW;

  typedef enum logic [4:0] {
    U_IDLE   = 5'b00001,
    U_FIND_A = 5'b00010,
    U_FIND_B = 5'b00100,
    U_LINK   = 5'b01000,
    U_BUMP   = 5'b10000
  } ust_t;

  ust_t ust, ust_next;

  // Entry layout: {rank, parent}
  logic [EW-1:0] uf_mem [CELLS];
  logic [EW-1:0] uf_rd;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [IW-1:0] cur;
  logic [IW-1:0] root_a;
  logic [IW-1:0] root_b;
  logic [RW-1:0] rank_a;
  logic [RW-1:0] rank_b;
  logic [RW-1:0] rank_inc;
  logic          done;
  logic          merged;
  logic          finish;

  logic [IW-1:0] rd_parent;
  logic [RW-1:0] rd_rank;
  logic          at_root;

  assign rd_parent = uf_rd[IW-1:0];
  assign rd_rank   = uf_rd[EW-1:IW];
  assign at_root   = (rd_parent == cur);
  assign rank_inc  = rank_a + RW'(1);

  // Walk parents one entry a cycle, then link the two roots
  always_comb begin
    ust_next = ust;
    rd_addr  = cur;
    wr_en    = 1'b0;
    wr_addr  = clr_idx;
    wr_data  = {RW'(0), clr_idx};
    unique case (ust)
      U_IDLE: begin
        rd_addr = a_idx;
        wr_en   = ctl.clear_wr;
        if (ctl.start) ust_next = U_FIND_A;
      end
      U_FIND_A: begin
        if (at_root) begin
          rd_addr  = b_idx;
          ust_next = U_FIND_B;
        end else begin
          rd_addr = rd_parent;
        end
      end
      U_FIND_B: begin
        rd_addr = rd_parent;
        if (at_root) ust_next = (cur == root_a) ? U_IDLE : U_LINK;
      end
      U_LINK: begin
        wr_en = 1'b1;
        if (rank_a < rank_b) begin
          wr_addr  = root_a;
          wr_data  = {rank_a, root_b};
          ust_next = U_IDLE;
        end else begin
          wr_addr  = root_b;
          wr_data  = {rank_b, root_a};
          ust_next = (rank_a == rank_b) ? U_BUMP : U_IDLE;
        end
      end
      U_BUMP: begin
        wr_en    = 1'b1;
        wr_addr  = root_a;
        wr_data  = {rank_inc, root_a};
        ust_next = U_IDLE;
      end
      default: ust_next = U_IDLE;
    endcase
  end

  assign finish = ((ust == U_FIND_B) && at_root && (cur == root_a)) ||
                  ((ust == U_LINK) && (rank_a != rank_b)) ||
                  (ust == U_BUMP);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ust  <= U_IDLE;
      done <= 1'b0;
    end else begin
      ust  <= ust_next;
      done <= finish;
    end
  end

  // Track the walk and capture roots
  always_ff @(posedge clk) begin
    case (ust)
      U_IDLE: cur <= a_idx;
      U_FIND_A: begin
        if (at_root) begin
          root_a <= cur;
          rank_a <= rd_rank;
          cur    <= b_idx;
        end else begin
          cur <= rd_parent;
        end
      end
      U_FIND_B: begin
        if (at_root) begin
          root_b <= cur;
          rank_b <= rd_rank;
          merged <= (cur != root_a);
        end else begin
          cur <= rd_parent;
        end
      end
      default: ;
    endcase
  end

  // Parent/rank memory
  always_ff @(posedge clk) begin
    if (wr_en) uf_mem[wr_addr] <= wr_data;
    uf_rd <= uf_mem[rd_addr];
  end

  assign sts.done   = done;
  assign sts.merged = merged;

`ifndef NO_ASSERTIONS
  a_link_distinct: assert property (@(posedge clk) disable iff (rst)
    (ust == U_LINK) |-> (root_a != root_b))
    else $error("link of a root to itself");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> (ust == U_IDLE))
    else $error("union started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");
`endif

endmodule
